// ===== rtl/bas_pkg.sv =====
`timescale 1ns / 1ps

package bas_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = IDX_W + 1;
    localparam int DATA_W        = 23;

    // Granule rounding: count / 64000 = (count >> 9) / 125,
    // and x / 125 = (x * 8389) >> 20 exactly for x below 2^14.
    localparam int GRANULE_BYTES = 64000;
    localparam int GRAN_SHIFT    = 9;
    localparam int GRAN_RECIP    = 8389;
    localparam int RECIP_SHIFT   = 20;
    localparam int PART_W        = DATA_W - GRAN_SHIFT;
    localparam int RECIP_W       = 14;
    localparam int QUOT_W        = 8;

    localparam logic [DATA_W-1:0] ARENA_RESET = 23'd6553600;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_REALLOC = 3'd1,
        CMD_SIZE    = 3'd2,
        CMD_ROUND   = 3'd3,
        CMD_CLEAR   = 3'd4
    } cmd_code_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_SPACE   = 3'd1,
        STS_NULL_FAULT = 3'd2,
        STS_NOT_FOUND  = 3'd3,
        STS_TABLE_FULL = 3'd4
    } status_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_RND_PROD,
        ST_RND_SUM,
        ST_RND_CHK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic exec;
        logic search_run;
        logic rnd_prod;
        logic rnd_sum;
        logic rnd_chk;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      present;
        logic      search_done;
        logic      out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/bas_ctrl.sv =====
`timescale 1ns / 1ps

module bas_ctrl
    import bas_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (stat.cmd == CMD_SIZE && stat.present)
                begin
                    state_next = ST_SEARCH;
                end
                else if (stat.cmd == CMD_ROUND)
                begin
                    state_next = ST_RND_PROD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEARCH:
            begin
                if (stat.search_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RND_PROD: state_next = ST_RND_SUM;
            ST_RND_SUM:  state_next = ST_RND_CHK;
            ST_RND_CHK:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            ST_EXEC:     cmd.exec       = 1'b1;
            ST_SEARCH:   cmd.search_run = 1'b1;
            ST_RND_PROD: cmd.rnd_prod   = 1'b1;
            ST_RND_SUM:  cmd.rnd_sum    = 1'b1;
            ST_RND_CHK:  cmd.rnd_chk    = 1'b1;
            ST_DONE:     cmd.load_out   = !stat.out_busy;
            default:     cmd            = '0;
        endcase
    end

endmodule

// ===== rtl/bas_dp.sv =====
`timescale 1ns / 1ps

module bas_dp
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctrl_cmd_t         cmd,
    output dp_stat_t          stat,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data,
    input  logic [2:0]        command,
    input  logic [DATA_W-1:0] byte_count,
    input  logic              handle_present,
    input  logic [DATA_W-1:0] handle_offset,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output logic [2:0]        status,
    output logic [DATA_W-1:0] block_offset,
    output logic [DATA_W-1:0] size_value
);

    // latched request
    cmd_code_t         rq_cmd_reg;
    logic [DATA_W-1:0] rq_count_reg;
    logic              rq_present_reg;
    logic [DATA_W-1:0] rq_handle_reg;

    // arena state
    logic [DATA_W-1:0] arena_reg;
    logic [DATA_W-1:0] cursor_reg;
    logic [DATA_W-1:0] cursor_next;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [CNT_W-1:0]  entry_count_next;

    // table: {offset, size} per entry
    logic [2*DATA_W-1:0] table_mem [TABLE_ENTRIES];
    logic [2*DATA_W-1:0] mem_q_reg;
    logic                mem_we;
    logic                mem_re;

    // search
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] rd_idx_next;
    logic             pend_reg;
    logic             pend_next;
    logic             hit;

    // rounding
    logic [QUOT_W-1:0]   quot_reg;
    logic [QUOT_W-1:0]   quot_next;
    logic [DATA_W:0]     prod_reg;
    logic [DATA_W:0]     rounded_reg;
    logic [PART_W+RECIP_W-1:0] recip_prod;
    logic [DATA_W+1:0]   rnd_total;

    // take
    logic [DATA_W:0] take_sum;
    logic            no_space;
    logic            table_full;

    // result and output stage
    status_code_t      res_status_reg;
    status_code_t      res_status_next;
    logic [DATA_W-1:0] res_offset_reg;
    logic [DATA_W-1:0] res_offset_next;
    logic [DATA_W-1:0] res_size_reg;
    logic [DATA_W-1:0] res_size_next;
    logic              out_valid_reg;
    status_code_t      out_status_reg;
    logic [DATA_W-1:0] out_offset_reg;
    logic [DATA_W-1:0] out_size_reg;

    assign take_sum   = {1'b0, cursor_reg} + {1'b0, rq_count_reg};
    assign no_space   = take_sum > {1'b0, arena_reg};
    assign table_full = entry_count_reg == CNT_W'(TABLE_ENTRIES);
    assign recip_prod = (PART_W+RECIP_W)'(rq_count_reg[DATA_W-1:GRAN_SHIFT])
                      * (PART_W+RECIP_W)'(GRAN_RECIP);
    assign rnd_total  = {1'b0, rounded_reg} + {2'b00, cursor_reg};
    assign hit        = pend_reg && (mem_q_reg[2*DATA_W-1:DATA_W] == rq_handle_reg);

    assign stat.cmd         = rq_cmd_reg;
    assign stat.present     = rq_present_reg;
    assign stat.search_done = hit || (!pend_reg && (rd_idx_reg == entry_count_reg));
    assign stat.out_busy    = out_valid_reg && !rsp_ready;

    always_comb
    begin
        cursor_next      = cursor_reg;
        entry_count_next = entry_count_reg;
        res_status_next  = res_status_reg;
        res_offset_next  = res_offset_reg;
        res_size_next    = res_size_reg;
        rd_idx_next      = rd_idx_reg;
        pend_next        = pend_reg;
        quot_next        = quot_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;

        if (cmd.exec)
        begin
            res_status_next = STS_OK;
            res_offset_next = '0;
            res_size_next   = '0;
            unique case (rq_cmd_reg)
                CMD_ALLOC, CMD_REALLOC:
                begin
                    priority if (rq_cmd_reg == CMD_REALLOC && !rq_present_reg)
                    begin
                        res_status_next = STS_NULL_FAULT;
                    end
                    else if (no_space)
                    begin
                        res_status_next = STS_NO_SPACE;
                    end
                    else if (table_full)
                    begin
                        res_status_next = STS_TABLE_FULL;
                    end
                    else
                    begin
                        mem_we           = 1'b1;
                        entry_count_next = entry_count_reg + 1'b1;
                        cursor_next      = take_sum[DATA_W-1:0];
                        res_offset_next  = cursor_reg;
                    end
                end
                CMD_SIZE:
                begin
                    res_status_next = STS_NOT_FOUND;
                    rd_idx_next     = '0;
                    pend_next       = 1'b0;
                end
                CMD_ROUND:
                begin
                    quot_next = recip_prod[RECIP_SHIFT +: QUOT_W];
                end
                CMD_CLEAR:
                begin
                    cursor_next      = '0;
                    entry_count_next = '0;
                end
                default:
                begin
                    res_status_next = STS_OK;
                end
            endcase
        end

        if (cmd.search_run)
        begin
            if (hit)
            begin
                res_status_next = STS_OK;
                res_size_next   = mem_q_reg[DATA_W-1:0];
            end
            // one table read per cycle, compare on the next
            if (rd_idx_reg < entry_count_reg)
            begin
                mem_re      = 1'b1;
                pend_next   = 1'b1;
                rd_idx_next = rd_idx_reg + 1'b1;
            end
            else
            begin
                pend_next = 1'b0;
            end
        end

        if (cmd.rnd_chk)
        begin
            if (rnd_total > {2'b00, arena_reg})
            begin
                res_status_next = STS_NO_SPACE;
            end
            else
            begin
                res_size_next = rounded_reg[DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[entry_count_reg[IDX_W-1:0]] <= {cursor_reg, rq_count_reg};
        end
        if (mem_re)
        begin
            mem_q_reg <= table_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rq_cmd_reg     <= cmd_code_t'(command);
            rq_count_reg   <= byte_count;
            rq_present_reg <= handle_present;
            rq_handle_reg  <= handle_offset;
        end
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_offset_reg <= res_offset_next;
        res_size_reg   <= res_size_next;
        rd_idx_reg     <= rd_idx_next;
        if (cmd.rnd_prod)
        begin
            prod_reg <= quot_reg * (DATA_W+1)'(GRANULE_BYTES);
        end
        if (cmd.rnd_sum)
        begin
            rounded_reg <= (prod_reg == {1'b0, rq_count_reg}) ? prod_reg
                         : prod_reg + (DATA_W+1)'(GRANULE_BYTES);
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_offset_reg <= res_offset_reg;
            out_size_reg   <= res_size_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arena_reg       <= ARENA_RESET;
            cursor_reg      <= '0;
            entry_count_reg <= '0;
            pend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                arena_reg <= cfg_wr_data;
            end
            cursor_reg      <= cursor_next;
            entry_count_reg <= entry_count_next;
            pend_reg        <= pend_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign block_offset = out_offset_reg;
    assign size_value   = out_size_reg;

endmodule

// ===== rtl/bump_allocator_with_size_table_unit.sv =====
// One request in flight; the next is taken in the cycle after the response is loaded into
// the output register. A size query walks the table reading one entry per cycle.
// Reset (rst_n, async, active low) empties cursor and table, arena_reg = 6553600.
`timescale 1ns / 1ps

module bump_allocator_with_size_table_unit
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration: arena size
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data,
    // request channel
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [2:0]        command,
    input  logic [DATA_W-1:0] byte_count,
    input  logic              handle_present,
    input  logic [DATA_W-1:0] handle_offset,
    // response channel
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [2:0]        status,
    output logic [DATA_W-1:0] block_offset,
    output logic [DATA_W-1:0] size_value
);

    // The controller steps each request through its phases:
    //   exec     - decode; allocate/reallocate/reset, unused codes and null size queries finish here
    //   search   - size query, table walk, one entry per cycle (pipelined read)
    //   rnd_*    - round-up: product, ceil, space check on the reciprocal quotient taken in exec
    //   done     - wait for a free output register, then load it
    // The output register lets a finished response wait while the next request
    // is taken.

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    bas_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (dp_stat),
        .cmd       (ctrl_cmd)
    );

    bas_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctrl_cmd),
        .stat           (dp_stat),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .command        (command),
        .byte_count     (byte_count),
        .handle_present (handle_present),
        .handle_offset  (handle_offset),
        .rsp_ready      (rsp_ready),
        .rsp_valid      (rsp_valid),
        .status         (status),
        .block_offset   (block_offset),
        .size_value     (size_value)
    );

endmodule

// ===== sim/bump_alloc_checker.sv =====
`timescale 1ns / 1ps

module bump_alloc_checker
    import bas_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [DATA_W-1:0] cfg_wr_data,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic [2:0]        command,
    input  logic [DATA_W-1:0] byte_count,
    input  logic              handle_present,
    input  logic [DATA_W-1:0] handle_offset,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic [2:0]        status,
    input  logic [DATA_W-1:0] block_offset,
    input  logic [DATA_W-1:0] size_value,
    output int                mismatches,
    output int                open_count,
    output int                checked_count
);

    typedef struct packed {
        logic [2:0]        cmd;
        logic [2:0]        status;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] size;
    } reply_t;

    // shadow of the allocator state
    logic [DATA_W-1:0] arena_size   = ARENA_RESET;
    logic [DATA_W-1:0] bump_ptr     = '0;
    int                live_entries = 0;
    logic [DATA_W-1:0] entry_base [TABLE_ENTRIES];
    logic [DATA_W-1:0] entry_len  [TABLE_ENTRIES];

    reply_t            awaited_replies [$];
    int                fail_tally = 0;
    int                compared   = 0;

    // space is checked before table room
    function automatic reply_t claim_block(input logic [2:0] cmd,
                                           input logic [DATA_W-1:0] cnt);
        reply_t r;
        r        = '0;
        r.cmd    = cmd;
        r.status = STS_OK;
        if ({1'b0, bump_ptr} + {1'b0, cnt} > {1'b0, arena_size})
            r.status = STS_NO_SPACE;
        else if (live_entries >= TABLE_ENTRIES)
            r.status = STS_TABLE_FULL;
        else
        begin
            entry_base[live_entries] = bump_ptr;
            entry_len[live_entries]  = cnt;
            live_entries++;
            r.offset = bump_ptr;
            bump_ptr = bump_ptr + cnt;
        end
        return r;
    endfunction

    function automatic reply_t serve_request(input logic [2:0]        cmd,
                                             input logic [DATA_W-1:0] cnt,
                                             input logic              present,
                                             input logic [DATA_W-1:0] handle);
        reply_t r;
        int     idx;
        int     granules;
        int     rounded;
        r        = '0;
        r.cmd    = cmd;
        r.status = STS_OK;
        case (cmd)
            CMD_ALLOC:
                r = claim_block(cmd, cnt);
            CMD_REALLOC:
                if (!present)
                    r.status = STS_NULL_FAULT;
                else
                    r = claim_block(cmd, cnt);
            CMD_SIZE:
            begin
                // first matching entry wins
                r.status = STS_NOT_FOUND;
                if (present)
                begin
                    for (idx = 0; idx < live_entries && r.status != STS_OK; idx++)
                    begin
                        if (entry_base[idx] == handle)
                        begin
                            r.status = STS_OK;
                            r.size   = entry_len[idx];
                        end
                    end
                end
            end
            CMD_ROUND:
            begin
                granules = cnt / GRANULE_BYTES;
                if (cnt % GRANULE_BYTES != 0)
                    granules++;
                rounded = granules * GRANULE_BYTES;
                if (rounded + bump_ptr > arena_size)
                    r.status = STS_NO_SPACE;
                else
                    r.size = DATA_W'(rounded);
            end
            CMD_CLEAR:
            begin
                bump_ptr     = '0;
                live_entries = 0;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic void check_field(input string             name,
                                        input logic [2:0]        cmd,
                                        input logic [DATA_W-1:0] want_v,
                                        input logic [DATA_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: command %0d %s expected %0d actual %0d",
                     $time, cmd, name, want_v, got_v);
            fail_tally++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        reply_t want;
        if (!rst_n)
        begin
            arena_size   = ARENA_RESET;
            bump_ptr     = '0;
            live_entries = 0;
            awaited_replies.delete();
            mismatches    <= 0;
            open_count    <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: response with no request pending (status %0d offset %0d size %0d)",
                             $time, status, block_offset, size_value);
                    fail_tally++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    compared++;
                    check_field("status", want.cmd, DATA_W'(want.status), DATA_W'(status));
                    check_field("block_offset", want.cmd, want.offset, block_offset);
                    check_field("size_value", want.cmd, want.size, size_value);
                end
            end
            if (req_valid && req_ready)
                awaited_replies.push_back(serve_request(command, byte_count,
                                                        handle_present, handle_offset));
            // register write takes effect after this edge
            if (cfg_wr_en)
                arena_size = cfg_wr_data;
            mismatches    <= fail_tally;
            open_count    <= awaited_replies.size();
            checked_count <= compared;
        end
    end

endmodule

// ===== sim/tb_bump_allocator_with_size_table_unit.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the bump allocator. Checking lives in bump_alloc_checker,
// which watches both channels and the arena register from beside the block.
module tb_bump_allocator_with_size_table_unit;
    import bas_pkg::*;

    // codes 5..7 carry no meaning; the block must answer them with all zeros
    localparam logic [2:0]        CMD_SPARE_LO = 3'd5;
    localparam logic [2:0]        CMD_SPARE_HI = 3'd7;
    localparam logic [DATA_W-1:0] ARENA_MAX    = '1;

    // The limit covers the slowest legal run: ~580 requests, each with up to a full table
    // walk, the longest sender gap and the longest receiver stall.
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int FILL_REQUESTS = 200;
    localparam int RANDOM_A      = 140;
    localparam int RANDOM_B      = 100;
    localparam int RANDOM_C      = 90;
    localparam int DRAIN_CYCLES  = 16;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [DATA_W-1:0] cfg_wr_data;
    logic              req_valid;
    logic              req_ready;
    logic [2:0]        command;
    logic [DATA_W-1:0] byte_count;
    logic              handle_present;
    logic [DATA_W-1:0] handle_offset;
    logic              rsp_valid;
    logic              rsp_ready;
    logic [2:0]        status;
    logic [DATA_W-1:0] block_offset;
    logic [DATA_W-1:0] size_value;

    int mismatches;
    int open_count;
    int checked_count;

    int cycles       = 0;
    int sent         = 0;
    int arena_writes = 0;
    int calm_left    = 0;   // requests left in a back-to-back burst

    bump_allocator_with_size_table_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .byte_count     (byte_count),
        .handle_present (handle_present),
        .handle_offset  (handle_offset),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .block_offset   (block_offset),
        .size_value     (size_value)
    );

    bump_alloc_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .command        (command),
        .byte_count     (byte_count),
        .handle_present (handle_present),
        .handle_offset  (handle_offset),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .block_offset   (block_offset),
        .size_value     (size_value),
        .mismatches     (mismatches),
        .open_count     (open_count),
        .checked_count  (checked_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gap after a request: mostly none or short, now and then long, and sometimes a
    // burst of back-to-back requests.
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Byte counts: mostly 64-byte multiples so that offsets line up with the handles
    // picked below, plus tiny, mid-range and full-range counts.
    function automatic logic [DATA_W-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return DATA_W'(64 * $urandom_range(0, 15));
        if (roll < 70)
            return DATA_W'($urandom_range(0, 255));
        if (roll < 85)
            return DATA_W'($urandom_range(0, 300000));
        return DATA_W'($urandom());
    endfunction

    // Presents one request and holds it until the block takes it, then maybe idles.
    // Valid is only lowered when a gap follows, so it never toggles within a step.
    task automatic send_request(input logic [2:0]        cmd,
                                input logic [DATA_W-1:0] cnt,
                                input logic              present,
                                input logic [DATA_W-1:0] handle);
        int gap;
        command        <= cmd;
        byte_count     <= cnt;
        handle_present <= present;
        handle_offset  <= handle;
        req_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stops issuing and waits until every request has been answered.
    task automatic drain_requests();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (open_count != 0);
    endtask

    // Arena register write; only called with the block idle.
    task automatic write_arena(input logic [DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        arena_writes++;
    endtask

    // One random request. Most are well-formed traffic that builds and probes the
    // table; the rest are spare codes and fully random noise.
    task automatic random_request();
        int                roll;
        logic [DATA_W-1:0] handle;
        logic [DATA_W-1:0] rnd_count;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 7)
            handle = DATA_W'(64 * $urandom_range(0, 200));
        else
            handle = DATA_W'($urandom());
        if ($urandom_range(0, 9) < 3)
            rnd_count = DATA_W'(64000 * $urandom_range(0, 131) + $urandom_range(0, 1));
        else
            rnd_count = pick_count();
        if (roll < 35)
            send_request(CMD_ALLOC, pick_count(), 1'($urandom_range(0, 1)),
                         DATA_W'($urandom()));
        else if (roll < 48)
            send_request(CMD_REALLOC, pick_count(), $urandom_range(0, 9) != 0, handle);
        else if (roll < 70)
            send_request(CMD_SIZE, DATA_W'($urandom()), $urandom_range(0, 15) != 0, handle);
        else if (roll < 84)
            send_request(CMD_ROUND, rnd_count, 1'($urandom_range(0, 1)),
                         DATA_W'($urandom()));
        else if (roll < 89)
            send_request(CMD_CLEAR, DATA_W'($urandom()), 1'($urandom_range(0, 1)),
                         DATA_W'($urandom()));
        else if (roll < 94)
            send_request(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), DATA_W'($urandom()),
                         1'($urandom_range(0, 1)), DATA_W'($urandom()));
        else
            send_request(3'($urandom_range(0, 7)), DATA_W'($urandom()),
                         1'($urandom_range(0, 1)), DATA_W'($urandom()));
    endtask

    // Response side: ready in runs of random length, stalls mostly short, a few long,
    // and some runs with no stall at all.
    initial
    begin : rsp_side
        int run_len;
        int stall_len;
        int roll;
        rsp_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                run_len = $urandom_range(60, 200);
            else
                run_len = $urandom_range(1, 30);
            rsp_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            roll = $urandom_range(0, 99);
            if (roll < 20)
                stall_len = 0;
            else if (roll < 80)
                stall_len = $urandom_range(1, 3);
            else if (roll < 96)
                stall_len = $urandom_range(4, 15);
            else
                stall_len = $urandom_range(30, 100);
            if (stall_len > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Timeout after %0d cycles, %0d responses still outstanding",
                 cycles, open_count);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        int n;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        req_valid      <= 1'b0;
        command        <= CMD_ALLOC;
        byte_count     <= '0;
        handle_present <= 1'b0;
        handle_offset  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- Directed requests, arena at its reset size ----
        send_request(CMD_SIZE, 0, 1'b1, 0);                 // empty table: not found
        send_request(CMD_ALLOC, 0, 1'b0, 0);                // zero-byte block at 0
        send_request(CMD_ALLOC, 100, 1'b0, 0);              // second block also at 0
        send_request(CMD_SIZE, 0, 1'b1, 0);                 // first match: the zero-size one
        send_request(CMD_SIZE, 0, 1'b0, 0);                 // null handle never matches
        send_request(CMD_REALLOC, 10, 1'b0, 0);             // null handle fault
        send_request(CMD_REALLOC, 200, 1'b1, 7654321);      // unknown handle still accepted
        send_request(CMD_REALLOC, ARENA_MAX, 1'b1, 100);    // reallocate with no space
        send_request(CMD_ALLOC, ARENA_MAX, 1'b1, ARENA_MAX);
        send_request(CMD_SIZE, 0, 1'b1, 100);
        send_request(CMD_SIZE, 0, 1'b1, ARENA_MAX);
        send_request(CMD_ROUND, 0, 1'b0, 0);
        send_request(CMD_ROUND, 1, 1'b0, 0);
        send_request(CMD_ROUND, DATA_W'(GRANULE_BYTES), 1'b0, 0);
        send_request(CMD_ROUND, DATA_W'(GRANULE_BYTES + 1), 1'b0, 0);
        send_request(CMD_ROUND, ARENA_MAX, 1'b1, ARENA_MAX); // rounds past 23 bits
        send_request(CMD_ROUND, 6400000, 1'b0, 0);           // fits with the cursor
        send_request(CMD_ROUND, 6553300, 1'b0, 0);           // rounds over the arena
        send_request(CMD_SPARE_LO, ARENA_MAX, 1'b1, ARENA_MAX);
        send_request(CMD_SPARE_HI, DATA_W'($urandom()), 1'b0, DATA_W'($urandom()));
        send_request(CMD_CLEAR, ARENA_MAX, 1'b1, ARENA_MAX);
        send_request(CMD_SIZE, 0, 1'b1, 100);               // gone after the clear
        send_request(CMD_ALLOC, ARENA_RESET, 1'b0, 0);      // fills the arena exactly
        send_request(CMD_ALLOC, 0, 1'b0, 0);                // zero bytes still fit at the end
        send_request(CMD_ALLOC, 1, 1'b0, 0);
        drain_requests();

        // ---- Random traffic, largest arena ----
        write_arena(ARENA_MAX);
        for (n = 0; n < RANDOM_A; n++)
            random_request();
        drain_requests();

        // ---- Arena shrunk below the cursor, then the empty arena ----
        send_request(CMD_CLEAR, 0, 1'b0, 0);
        send_request(CMD_ALLOC, 1000, 1'b0, 0);
        send_request(CMD_ALLOC, 0, 1'b0, 0);
        drain_requests();
        write_arena('0);
        send_request(CMD_ALLOC, 0, 1'b0, 0);
        send_request(CMD_REALLOC, 0, 1'b1, 0);
        send_request(CMD_ROUND, 0, 1'b0, 0);
        send_request(CMD_SIZE, 0, 1'b1, 0);
        send_request(CMD_REALLOC, 0, 1'b0, 0);
        send_request(CMD_CLEAR, 0, 1'b0, 0);
        send_request(CMD_ALLOC, 0, 1'b0, 0);
        send_request(CMD_ROUND, 0, 1'b0, 0);
        send_request(CMD_ALLOC, 1, 1'b0, 0);
        send_request(CMD_ROUND, 1, 1'b0, 0);
        drain_requests();

        // ---- Build a long table of tiny blocks ----
        // Tiny sizes keep the cursor low so probe handles often hit.
        write_arena(ARENA_MAX);
        send_request(CMD_CLEAR, 0, 1'b0, 0);
        for (n = 0; n < FILL_REQUESTS; n++)
        begin
            if ($urandom_range(0, 39) == 0)
                send_request(CMD_SIZE, 0, 1'b1, DATA_W'($urandom_range(0, 2 * n)));
            send_request(($urandom_range(0, 3) == 0) ? CMD_REALLOC : CMD_ALLOC,
                         DATA_W'($urandom_range(0, 3)), 1'b1, DATA_W'($urandom()));
        end
        send_request(CMD_SIZE, 0, 1'b1, ARENA_MAX);         // walks the whole table
        send_request(CMD_SIZE, 0, 1'b1, 0);
        send_request(CMD_REALLOC, 5, 1'b0, 0);              // null checked before anything
        send_request(CMD_REALLOC, ARENA_MAX, 1'b1, 0);      // no space with a long table
        send_request(CMD_ALLOC, 0, 1'b0, 0);                // zero bytes at the table's end
        send_request(CMD_ROUND, DATA_W'(GRANULE_BYTES), 1'b0, 0);
        send_request(CMD_CLEAR, 0, 1'b0, 0);
        send_request(CMD_ALLOC, 10, 1'b0, 0);
        drain_requests();

        // ---- Random traffic, small arena so space runs out often ----
        write_arena(DATA_W'($urandom_range(20000, 400000)));
        for (n = 0; n < RANDOM_B; n++)
            random_request();
        drain_requests();

        // ---- Random traffic, back at the reset size ----
        write_arena(ARENA_RESET);
        for (n = 0; n < RANDOM_C; n++)
            random_request();
        drain_requests();

        // let any stray response show up
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (directed, table build, random) over %0d arena sizes in %0d cycles",
                 sent, arena_writes, cycles);
        $display("%0d responses compared field by field, %0d mismatches",
                 checked_count, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
